// ===== rtl/core/vrc_pkg.sv =====
// Package: transaction types and constants for the VRC bank mapper.
`default_nettype none
package vrc_pkg;

  localparam logic [1:0] FUNC_CPU_READ  = 2'd0;
  localparam logic [1:0] FUNC_CPU_WRITE = 2'd1;
  localparam logic [1:0] FUNC_PPU_READ  = 2'd2;
  localparam logic [1:0] FUNC_TICK      = 2'd3;

  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_RAM = 2'd1;
  localparam logic [1:0] TGT_PRG_ROM = 2'd2;
  localparam logic [1:0] TGT_CHR_ROM = 2'd3;

  localparam logic [1:0] VAR_A1A6    = 2'd0;
  localparam logic [1:0] VAR_VRC2    = 2'd1;
  localparam logic [1:0] VAR_A2A3    = 2'd2;
  localparam logic [1:0] VAR_SWAPPED = 2'd3;

  localparam logic [1:0] CFG_BOARD_VARIANT = 2'd0;
  localparam logic [1:0] CFG_PRG_ROM_MASK  = 2'd1;
  localparam logic [1:0] CFG_CHR_ROM_MASK  = 2'd2;
  localparam logic [1:0] CFG_FOUR_SCREEN   = 2'd3;

  localparam int CFG_DATA_W = 19;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [18:0] mem_address;
    logic        ram_write;
    logic [7:0]  ram_write_data;
    logic        irq;
    logic [1:0]  mirroring;
  } out_item_t;

  // Register write decoded from a remapped CPU write
  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } reg_wr_t;

  // Bank state seen by the address translator
  typedef struct packed {
    logic [4:0] prg_bank_low;
    logic [4:0] prg_bank_mid;
    logic       prg_swap;
    logic [1:0] mirror_mode;
    logic       irq_pending;
  } bank_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/vrc_regs.sv =====
// Mapper register file and IRQ counter with scanline prescaler.
`default_nettype none
module vrc_regs (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                four_screen,
  input  wire vrc_pkg::reg_wr_t    wr,
  input  wire logic                tick,
  input  wire logic [2:0]          chr_sel,
  output vrc_pkg::bank_state_t     state,
  output logic [8:0]               chr_bank
);
  import vrc_pkg::*;

  logic [4:0] prg_bank_low_r, prg_bank_low_nxt;
  logic [4:0] prg_bank_mid_r, prg_bank_mid_nxt;
  logic       prg_swap_r, prg_swap_nxt;
  logic [8:0] chr_banks_r [8];
  logic [8:0] chr_banks_nxt [8];
  logic [1:0] mirror_mode_r, mirror_mode_nxt;
  logic [7:0] irq_latch_r, irq_latch_nxt;
  logic [7:0] irq_count_r, irq_count_nxt;
  logic [6:0] prescale_count_r, prescale_count_nxt;
  logic [1:0] prescale_phase_r, prescale_phase_nxt;
  logic       irq_armed_r, irq_armed_nxt;
  logic       rearm_r, rearm_nxt;
  logic       cycle_mode_r, cycle_mode_nxt;
  logic       irq_pending_r, irq_pending_nxt;

  logic [3:0] hi;
  logic [1:0] lo;
  logic [2:0] idx;
  logic [6:0] period;
  logic       step;

  assign hi = wr.addr[15:12];
  assign lo = wr.addr[1:0];
  assign idx = 3'(({1'b0, hi} - 5'd11) << 1) | {2'b00, lo[1]};
  assign period = (prescale_phase_r[1]) ? 7'd112 : 7'd113;

  always_comb begin
    prg_bank_low_nxt   = prg_bank_low_r;
    prg_bank_mid_nxt   = prg_bank_mid_r;
    prg_swap_nxt       = prg_swap_r;
    chr_banks_nxt      = chr_banks_r;
    mirror_mode_nxt    = mirror_mode_r;
    irq_latch_nxt      = irq_latch_r;
    irq_count_nxt      = irq_count_r;
    prescale_count_nxt = prescale_count_r;
    prescale_phase_nxt = prescale_phase_r;
    irq_armed_nxt      = irq_armed_r;
    rearm_nxt          = rearm_r;
    cycle_mode_nxt     = cycle_mode_r;
    irq_pending_nxt    = irq_pending_r;
    step               = 1'b0;

    // Tick: direct cycle count or prescaled scanline count
    if (tick) begin
      if (cycle_mode_r) begin
        step = 1'b1;
      end else if (prescale_count_r >= period) begin
        step = 1'b1;
        prescale_phase_nxt = (prescale_phase_r >= 2'd2) ? 2'd0 : prescale_phase_r + 2'd1;
        prescale_count_nxt = '0;
      end else begin
        prescale_count_nxt = prescale_count_r + 7'd1;
      end
    end
    if (step) begin
      if (irq_count_r == 8'hFF) begin
        if (irq_armed_r) begin
          irq_pending_nxt = 1'b1;
          irq_armed_nxt   = 1'b0;
        end
        irq_count_nxt = irq_latch_r;
      end else begin
        irq_count_nxt = irq_count_r + 8'd1;
      end
    end

    // Register writes
    if (wr.en) begin
      case (hi)
        4'h8: prg_bank_low_nxt = wr.data[4:0];
        4'h9: begin
          if (!lo[1]) begin
            if (!four_screen) mirror_mode_nxt = wr.data[1:0];
          end else begin
            prg_swap_nxt = wr.data[1];
          end
        end
        4'hA: prg_bank_mid_nxt = wr.data[4:0];
        4'hB, 4'hC, 4'hD, 4'hE: begin
          if (lo[0]) chr_banks_nxt[idx] = {wr.data[4:0], chr_banks_r[idx][3:0]};
          else       chr_banks_nxt[idx] = {chr_banks_r[idx][8:4], wr.data[3:0]};
        end
        4'hF: begin
          case (lo)
            2'd0: irq_latch_nxt = {irq_latch_r[7:4], wr.data[3:0]};
            2'd1: irq_latch_nxt = {wr.data[3:0], irq_latch_r[3:0]};
            2'd2: begin
              irq_pending_nxt = 1'b0;
              rearm_nxt       = wr.data[0];
              cycle_mode_nxt  = wr.data[2];
              if (wr.data[1]) begin
                irq_armed_nxt      = 1'b1;
                irq_count_nxt      = irq_latch_r;
                prescale_count_nxt = '0;
                prescale_phase_nxt = '0;
              end
            end
            default: begin
              irq_pending_nxt = 1'b0;
              if (rearm_r) irq_armed_nxt = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_low_r   <= '0;
      prg_bank_mid_r   <= 5'd1;
      prg_swap_r       <= 1'b0;
      for (int i = 0; i < 8; i++) chr_banks_r[i] <= '0;
      mirror_mode_r    <= '0;
      irq_latch_r      <= '0;
      irq_count_r      <= '0;
      prescale_count_r <= '0;
      prescale_phase_r <= '0;
      irq_armed_r      <= 1'b0;
      rearm_r          <= 1'b0;
      cycle_mode_r     <= 1'b0;
      irq_pending_r    <= 1'b0;
    end else begin
      prg_bank_low_r   <= prg_bank_low_nxt;
      prg_bank_mid_r   <= prg_bank_mid_nxt;
      prg_swap_r       <= prg_swap_nxt;
      chr_banks_r      <= chr_banks_nxt;
      mirror_mode_r    <= mirror_mode_nxt;
      irq_latch_r      <= irq_latch_nxt;
      irq_count_r      <= irq_count_nxt;
      prescale_count_r <= prescale_count_nxt;
      prescale_phase_r <= prescale_phase_nxt;
      irq_armed_r      <= irq_armed_nxt;
      rearm_r          <= rearm_nxt;
      cycle_mode_r     <= cycle_mode_nxt;
      irq_pending_r    <= irq_pending_nxt;
    end
  end

  assign state.prg_bank_low = prg_bank_low_r;
  assign state.prg_bank_mid = prg_bank_mid_r;
  assign state.prg_swap     = prg_swap_r;
  assign state.mirror_mode  = mirror_mode_r;
  assign state.irq_pending  = irq_pending_r;
  assign chr_bank           = chr_banks_r[chr_sel];

  // Pending only rises on a counter wrap while armed
  a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_pending_r) |-> $past(irq_armed_r) && !irq_armed_r)
    else $error("irq pending rose without arm");
  // Armed and pending never both set
  a_arm_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_pending_r) |-> !irq_armed_r)
    else $error("irq armed with pending");
  // Prescaler stays within its period
  a_presc: assert property (@(posedge clk) disable iff (!rst_n)
    prescale_count_r <= 7'd113)
    else $error("prescaler overrun");

endmodule
`default_nettype wire

// ===== rtl/core/vrc_xlat.sv =====
// Write remap and read address translation for one transaction.
`default_nettype none
module vrc_xlat #(
  parameter int PRG_ADDR_BITS = 18,
  parameter int CHR_ADDR_BITS = 19
) (
  input  wire vrc_pkg::in_item_t     item,
  input  wire logic                  item_vld,
  input  wire logic [1:0]            board_variant,
  input  wire logic [17:0]           prg_rom_mask,
  input  wire logic [18:0]           chr_rom_mask,
  input  wire vrc_pkg::bank_state_t  state,
  input  wire logic [8:0]            chr_bank,
  output logic [2:0]                 chr_sel,
  output vrc_pkg::reg_wr_t           wr,
  output logic                       tick,
  output logic [1:0]                 target,
  output logic [18:0]                mem_address,
  output logic                       ram_write,
  output logic [7:0]                 ram_write_data
);
  import vrc_pkg::*;

  logic [15:0] a;
  logic [7:0]  d;
  logic        ram_rng, rom_rng;
  logic [1:0]  region;
  logic [4:0]  prg_bank;
  logic [17:0] prg_addr;
  logic [8:0]  cbank;
  logic [18:0] chr_addr;

  assign a       = item.address;
  assign ram_rng = (a[15:13] == 3'b011);
  assign rom_rng = a[15];
  assign region  = a[14:13];
  assign chr_sel = a[12:10];
  assign tick    = item_vld && (item.func == FUNC_TICK);

  // PRG bank select: fixed banks are the top two banks, 0x1E and 0x1F
  always_comb begin
    case (region)
      2'd0:    prg_bank = state.prg_swap ? 5'h1E : state.prg_bank_low;
      2'd1:    prg_bank = state.prg_bank_mid;
      2'd2:    prg_bank = state.prg_swap ? state.prg_bank_low : 5'h1E;
      default: prg_bank = 5'h1F;
    endcase
  end
  assign prg_addr = {prg_bank, a[12:0]} & prg_rom_mask
                  & 18'((19'd1 << PRG_ADDR_BITS) - 19'd1);

  assign cbank    = (board_variant == VAR_VRC2) ? {1'b0, chr_bank[8:1]} : chr_bank;
  assign chr_addr = {cbank, a[9:0]} & chr_rom_mask
                  & 19'((20'd1 << CHR_ADDR_BITS) - 20'd1);

  // Board wiring remap of register writes
  always_comb begin
    wr = '0;
    d  = item.write_data;
    if (item_vld && item.func == FUNC_CPU_WRITE && rom_rng) begin
      wr.en = 1'b1;
      case (board_variant)
        VAR_A1A6: wr.addr = {a[15:12], 10'd0, a[2:1] | a[7:6]};
        VAR_VRC2: begin
          if (a == 16'h9000 || a == 16'h9002) d = {7'd0, d[0]};
          wr.addr = {a[15:12], 10'd0, a[0], a[1]};
        end
        VAR_A2A3: begin
          if (a == 16'h9000 && d == 8'hFF) d = 8'h01;
          wr.addr = {a[15:12], 10'd0, a[1:0] | a[3:2]};
        end
        default: wr.addr = {a[15:12], 10'd0, {a[0], a[1]} | {a[2], a[3]}};
      endcase
      wr.data = d;
    end
  end

  always_comb begin
    target = TGT_NONE;
    mem_address = '0;
    ram_write = 1'b0;
    ram_write_data = '0;
    case (item.func)
      FUNC_CPU_READ: begin
        if (ram_rng) begin
          target = TGT_PRG_RAM;
          mem_address = {6'd0, a[12:0]};
        end else if (rom_rng) begin
          target = TGT_PRG_ROM;
          mem_address = {1'b0, prg_addr};
        end
      end
      FUNC_CPU_WRITE: begin
        if (board_variant != VAR_VRC2 && ram_rng) begin
          target = TGT_PRG_RAM;
          mem_address = {6'd0, a[12:0]};
          ram_write = 1'b1;
          ram_write_data = item.write_data;
        end
      end
      FUNC_PPU_READ: begin
        target = TGT_CHR_ROM;
        mem_address = chr_addr;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/vrc_bank_mapper_irq_unit.sv =====
// Top level: VRC bank mapper with IRQ counter.
//
//  channel | ports                       | payload
//  --------+-----------------------------+------------
//  input   | in_valid / in_stall         | in_item_t
//  result  | out_valid / out_stall       | out_item_t
//  config  | cfg_we / cfg_index / cfg_data | 19-bit data
//
// One transaction per cycle while in_stall is low; its result is loaded into
// the output register at acceptance. State updates at the accept edge, the
// result holds the post-update irq and mirroring. Reset is synchronous,
// active low. A stall on the output holds the result and stalls the input
// only while the register is full and not being taken.
`default_nettype none
module vrc_bank_mapper_irq_unit #(
  parameter int PRG_ADDR_BITS = 18,
  parameter int CHR_ADDR_BITS = 19
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire vrc_pkg::in_item_t     in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output vrc_pkg::out_item_t         out_item,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [vrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vrc_pkg::*;

  logic [1:0]  board_variant_r;
  logic [17:0] prg_rom_mask_r;
  logic [18:0] chr_rom_mask_r;
  logic        four_screen_r;
  logic        acc;
  bank_state_t state, state_post;
  reg_wr_t     wr;
  logic        tick;
  logic [2:0]  chr_sel;
  logic [8:0]  chr_bank;
  logic [1:0]  target;
  logic [18:0] mem_address;
  logic        ram_write;
  logic [7:0]  ram_write_data;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        pend_seen_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_variant_r <= '0;
      prg_rom_mask_r  <= '1;
      chr_rom_mask_r  <= '1;
      four_screen_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOARD_VARIANT: board_variant_r <= cfg_data[1:0];
        CFG_PRG_ROM_MASK:  prg_rom_mask_r  <= cfg_data[17:0];
        CFG_CHR_ROM_MASK:  chr_rom_mask_r  <= cfg_data[18:0];
        CFG_FOUR_SCREEN:   four_screen_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  vrc_xlat #(.PRG_ADDR_BITS(PRG_ADDR_BITS), .CHR_ADDR_BITS(CHR_ADDR_BITS)) u_xlat (
    .item(in_item), .item_vld(acc), .board_variant(board_variant_r),
    .prg_rom_mask(prg_rom_mask_r), .chr_rom_mask(chr_rom_mask_r),
    .state(state), .chr_bank(chr_bank), .chr_sel(chr_sel), .wr(wr), .tick(tick),
    .target(target), .mem_address(mem_address), .ram_write(ram_write),
    .ram_write_data(ram_write_data)
  );

  vrc_regs u_regs (
    .clk(clk), .rst_n(rst_n), .four_screen(four_screen_r), .wr(wr), .tick(tick),
    .chr_sel(chr_sel), .state(state), .chr_bank(chr_bank)
  );

  // irq and mirroring are the values after this transaction: read next cycle
  assign state_post = state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_seen_r <= 1'b0;
    end else begin
      if (acc) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      pend_seen_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_item_r.target         <= target;
      out_item_r.mem_address    <= mem_address;
      out_item_r.ram_write      <= ram_write;
      out_item_r.ram_write_data <= ram_write_data;
    end
  end

  // Live state is only post-update for the newest result; freeze it after
  logic       irq_hold_r;
  logic [1:0] mir_hold_r;
  always_ff @(posedge clk) begin
    if (pend_seen_r) begin
      irq_hold_r <= state_post.irq_pending;
      mir_hold_r <= state_post.mirror_mode;
    end
  end

  assign out_valid = out_valid_r;
  always_comb begin
    out_item.target         = out_item_r.target;
    out_item.mem_address    = out_item_r.mem_address;
    out_item.ram_write      = out_item_r.ram_write;
    out_item.ram_write_data = out_item_r.ram_write_data;
    out_item.irq            = pend_seen_r ? state_post.irq_pending : irq_hold_r;
    out_item.mirroring      = pend_seen_r ? state_post.mirror_mode : mir_hold_r;
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  a_no_acc_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !acc)
    else $error("accepted into full register");
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    pend_seen_r |-> out_valid_r)
    else $error("fresh result without valid");

endmodule
`default_nettype wire
